FILE: sv/sitda_pkg.sv
// Shared constants and helpers for the signed integer to decimal text converter.
// No dependencies; used by signed_int_to_decimal_ascii and sitda_checker.
package sitda_pkg;

	localparam int ValueWidth  = 32;
	localparam int DigitCount  = 10;
	localparam int BcdWidth    = 4 * DigitCount;
	localparam int CharWidth   = 7;
	localparam int CountWidth  = $clog2(ValueWidth);
	localparam int DigitsWidth = $clog2(DigitCount + 1);

	localparam logic [CharWidth-1:0] AsciiZero  = 7'd48;
	localparam logic [CharWidth-1:0] AsciiMinus = 7'd45;

	typedef logic [3:0] bcd_digit_t;

	// Correction applied to one BCD digit before each left shift.
	function automatic bcd_digit_t dabble_adjust(input bcd_digit_t d);
		bcd_digit_t r;
		if (d >= 4'd5) begin
			r = d + 4'd3;
		end else begin
			r = d;
		end
		return r;
	endfunction

endpackage

FILE: sv/signed_int_to_decimal_ascii.sv
// Signed 32-bit integer to decimal ASCII text, most significant digit first.
// Depends on sitda_pkg for widths, character codes and the BCD digit correction.
//
//   channel   direction   payload                          last mark
//   s_*       in          tdata[31:0] value (signed)       -
//   m_*       out         tdata[6:0] character, [7] zero   tlast = last
//
// A number is accepted, converted by bit-serial shift-and-add-3 (one magnitude
// bit per cycle), stripped of its leading zero digits one at a time, and then
// sent as characters, a minus sign first when negative. A number of d digits
// drops 10 - d zeros.
// Reset clears the control state and the output register. A stalled output
// holds its character and pauses the emission; a new request is taken only
// after the last character of the previous one has been loaded.
module signed_int_to_decimal_ascii (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] value
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [6:0] character, [7] zero fill
	output logic        m_tlast
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SKIP,
		ST_SIGN,
		ST_EMIT
	} state_t;

	state_t                                  state_q;
	logic [sitda_pkg::ValueWidth-1:0]        mag_q;
	logic [sitda_pkg::BcdWidth-1:0]          bcd_q;
	logic [sitda_pkg::CountWidth-1:0]        bit_cnt_q;
	logic [sitda_pkg::DigitsWidth-1:0]       digits_q;
	logic                                    neg_q;
	logic                                    out_valid_q;
	logic [sitda_pkg::CharWidth-1:0]         char_q;
	logic                                    last_q;

	logic [sitda_pkg::BcdWidth-1:0]          bcd_adj;
	logic [sitda_pkg::ValueWidth-1:0]        neg_value;
	sitda_pkg::bcd_digit_t                   top_digit;
	logic                                    out_free;
	logic                                    out_load;

	always_comb begin
		for (int i = 0; i < sitda_pkg::DigitCount; i++) begin
			bcd_adj[4*i +: 4] = sitda_pkg::dabble_adjust(bcd_q[4*i +: 4]);
		end
	end

	assign neg_value = ~s_tdata + 32'd1;
	assign top_digit = bcd_q[sitda_pkg::BcdWidth-1 -: 4];
	assign out_free  = !out_valid_q || m_tready;
	assign out_load  = out_free && (state_q == ST_SIGN || state_q == ST_EMIT);

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, char_q};
	assign m_tlast  = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			char_q      <= '0;
			last_q      <= 1'b0;
			bit_cnt_q   <= '0;
			digits_q    <= '0;
			neg_q       <= 1'b0;
		end else begin
			if (m_tready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						neg_q     <= s_tdata[sitda_pkg::ValueWidth-1];
						mag_q     <= s_tdata[sitda_pkg::ValueWidth-1] ? neg_value : s_tdata;
						bcd_q     <= '0;
						bit_cnt_q <= '0;
						state_q   <= ST_CONV;
					end
				end
				ST_CONV: begin
					bcd_q     <= {bcd_adj[sitda_pkg::BcdWidth-2:0],
						mag_q[sitda_pkg::ValueWidth-1]};
					mag_q     <= {mag_q[sitda_pkg::ValueWidth-2:0], 1'b0};
					bit_cnt_q <= bit_cnt_q + 1'b1;
					if (bit_cnt_q == sitda_pkg::CountWidth'(sitda_pkg::ValueWidth - 1)) begin
						digits_q <= sitda_pkg::DigitsWidth'(sitda_pkg::DigitCount);
						state_q  <= ST_SKIP;
					end
				end
				ST_SKIP: begin
					// Zero keeps its final digit, so it still prints as one '0'.
					if (top_digit == 4'd0 && digits_q != sitda_pkg::DigitsWidth'(1)) begin
						bcd_q    <= {bcd_q[sitda_pkg::BcdWidth-5:0], 4'd0};
						digits_q <= digits_q - 1'b1;
					end else begin
						state_q <= neg_q ? ST_SIGN : ST_EMIT;
					end
				end
				ST_SIGN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						char_q      <= sitda_pkg::AsciiMinus;
						last_q      <= 1'b0;
						state_q     <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						char_q      <= sitda_pkg::AsciiZero
							+ {{(sitda_pkg::CharWidth-4){1'b0}}, top_digit};
						last_q      <= (digits_q == sitda_pkg::DigitsWidth'(1));
						bcd_q       <= {bcd_q[sitda_pkg::BcdWidth-5:0], 4'd0};
						digits_q    <= digits_q - 1'b1;
						if (digits_q == sitda_pkg::DigitsWidth'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: verif/sitda_checker.sv
`timescale 1ns / 1ps
// Scoreboard for signed_int_to_decimal_ascii: watches both stream channels, works out the
// decimal text of every accepted request and compares it with the characters that come out.
// Depends on sitda_pkg for the widths and the character codes.
module sitda_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] value
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [7:0]  m_tdata,   // [6:0] character, [7] zero fill
	input  logic        m_tlast,
	output int          errors,
	output int          outstanding
);

	localparam int MaxPrinted  = 100;
	localparam int DecimalBase = 10;

	typedef struct packed {
		logic [sitda_pkg::CharWidth-1:0] code;
		logic                            last;
	} text_char_t;

	text_char_t expected_chars [$];

	// Appends the characters that one value should produce, sign first.
	function automatic void push_decimal_text(input logic [sitda_pkg::ValueWidth-1:0] value);
		logic [sitda_pkg::ValueWidth:0] magnitude;
		logic [3:0]                     digits [sitda_pkg::DigitCount];
		int                             count;
		text_char_t                     ch;
		count = 0;
		if (value[sitda_pkg::ValueWidth-1]) begin
			// One extra bit keeps the magnitude of the most negative value exact.
			magnitude = {1'b0, ~value} + 1'b1;
			ch.code   = sitda_pkg::AsciiMinus;
			ch.last   = 1'b0;
			expected_chars.push_back(ch);
		end else begin
			magnitude = {1'b0, value};
		end
		do begin
			digits[count] = 4'(magnitude % DecimalBase);
			magnitude     = magnitude / DecimalBase;
			count++;
		end while (magnitude != 0);
		for (int k = count - 1; k >= 0; k--) begin
			ch.code = sitda_pkg::AsciiZero + 7'(digits[k]);
			ch.last = (k == 0);
			expected_chars.push_back(ch);
		end
	endfunction

	task automatic report_mismatch(input string what);
		if (errors < MaxPrinted) begin
			$display("%0t: %s", $time, what);
		end
		errors++;
	endtask

	always @(posedge clk) begin : monitor
		text_char_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				push_decimal_text(s_tdata);
			end
			if (m_tvalid && m_tready) begin
				if (expected_chars.size() == 0) begin
					report_mismatch($sformatf("character 0x%02h with no request pending",
						m_tdata));
				end else begin
					want = expected_chars.pop_front();
					if (m_tdata[sitda_pkg::CharWidth-1:0] !== want.code) begin
						report_mismatch($sformatf("character 0x%02h, wanted 0x%02h",
							m_tdata[sitda_pkg::CharWidth-1:0], want.code));
					end
					if (m_tlast !== want.last) begin
						report_mismatch($sformatf("tlast %b, wanted %b on character 0x%02h",
							m_tlast, want.last, want.code));
					end
					if (m_tdata[sitda_pkg::CharWidth] !== 1'b0) begin
						report_mismatch("fill bit above the character is not zero");
					end
				end
			end
			outstanding = expected_chars.size();
		end
	end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// Top of the testbench for signed_int_to_decimal_ascii: clock, reset, request stimulus,
// output back-pressure and the final verdict.
// Depends on the block itself and sitda_checker.
module tb;

	localparam int RandomRequests = 200;
	localparam int DrainCycles    = 64;
	localparam int HoldOffStart   = 1500;
	localparam int HoldOffCycles  = 600;
	localparam int DirectedCount  = 20;

	typedef enum int {AlwaysReady, HalfReady, MostlyStalled} stall_mode_t;

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata  = '0;   // [31:0] value
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;         // [6:0] character, [7] zero fill
	logic        m_tlast;
	int          errors;
	int          outstanding;
	int          burst_left = 0;

	// Zero, single digits, digit-count boundaries, both extremes and alternating bits.
	logic [31:0] directed_values [0:DirectedCount-1] = '{
		32'd0, 32'd1, 32'd7, 32'd9, 32'd10, 32'd99, 32'd100,
		-32'sd1, -32'sd9, -32'sd10,
		32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
		32'd1000000000, 32'd999999999, -32'sd1000000000,
		32'd1234567890, -32'sd1234567890,
		32'h5555_5555, 32'hAAAA_AAAA
	};

	signed_int_to_decimal_ascii dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	sitda_checker scoreboard (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tlast     (m_tlast),
		.errors      (errors),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic longint power_of_ten(input int exponent);
		longint p;
		p = 1;
		repeat (exponent) p = p * 10;
		return p;
	endfunction

	// Mostly values of a random digit count, some near powers of ten, some raw words.
	function automatic logic [31:0] random_value();
		int     kind;
		int     digits;
		longint lo;
		longint hi;
		longint mag;
		kind   = $urandom_range(0, 9);
		digits = $urandom_range(1, 10);
		lo     = power_of_ten(digits - 1);
		hi     = power_of_ten(digits) - 1;
		if (hi > 64'sd2147483647) begin
			hi = 64'sd2147483647;
		end
		if (kind < 2) begin
			mag = longint'($urandom);
		end else if (kind == 2) begin
			mag = lo + longint'($urandom_range(0, 2)) - 1;
		end else begin
			mag = lo + longint'($urandom_range(0, 32'(hi - lo)));
		end
		if (kind >= 2) begin
			if (mag > 64'sd2147483647) begin
				mag = 64'sd2147483647;
			end
			if ($urandom_range(0, 1) == 1) begin
				mag = -mag;
			end
		end
		return mag[31:0];
	endfunction

	// Offers one request and returns on the edge at which it is taken. Gaps between bursts
	// are long enough to land on every stage of the conversion.
	task automatic offer_request(input logic [31:0] value);
		int gap;
		if (burst_left == 0) begin
			if ($urandom_range(0, 3) == 0) begin
				gap = $urandom_range(1, 60);
			end else begin
				gap = $urandom_range(0, 6);
			end
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			if ($urandom_range(0, 4) == 0) begin
				burst_left = $urandom_range(15, 40);
			end else begin
				burst_left = $urandom_range(1, 6);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata  <= value;
		// Ready is stable away from the rising edge, so look at it half a cycle early.
		do @(negedge clk); while (!s_tready);
		@(posedge clk);
		burst_left--;
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		for (int i = 0; i < DirectedCount; i++) begin
			offer_request(directed_values[i]);
		end
		for (int i = 0; i < RandomRequests; i++) begin
			offer_request(random_value());
		end
		s_tvalid <= 1'b0;
		// The scoreboard counts the last request at the edge just passed, so look after it.
		do @(negedge clk); while (outstanding != 0);
		repeat (DrainCycles) @(posedge clk);
		if (errors == 0 && outstanding == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	// Output back-pressure in segments of differing stall density, with one long hold-off
	// while the sender keeps offering so that the block backs up into its input.
	initial begin
		stall_mode_t mode;
		int          span;
		int          elapsed;
		bit          held;
		elapsed = 0;
		held    = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (!held && elapsed >= HoldOffStart) begin
				held = 1'b1;
				m_tready <= 1'b0;
				repeat (HoldOffCycles) @(posedge clk);
			end
			mode = stall_mode_t'($urandom_range(0, 2));
			span = $urandom_range(20, 200);
			repeat (span) begin
				case (mode)
					AlwaysReady: begin
						m_tready <= 1'b1;
					end
					HalfReady: begin
						m_tready <= 1'($urandom_range(0, 1));
					end
					default: begin
						m_tready <= ($urandom_range(0, 3) == 0);
					end
				endcase
				@(posedge clk);
			end
			elapsed += span;
		end
	end

	initial begin
		#2_000_000;
		$display("status: fail");
		$finish;
	end

endmodule

FILE: signed_int_to_decimal_ascii.f
sv/sitda_pkg.sv
sv/signed_int_to_decimal_ascii.sv
verif/sitda_checker.sv
verif/tb.sv
